// ===== src/ptrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrd_pkg - shared types and constants for the planar tile row decoder
// Depth codes, tile lengths, the tile store write request and the row job.
// ----------------------------------------------------------------------------
package ptrd_pkg;

    // tile_depth register codes
    localparam logic [2:0] DEPTH_NONE  = 3'd0;
    localparam logic [2:0] DEPTH_2BPP  = 3'd1;
    localparam logic [2:0] DEPTH_4BPP  = 3'd2;
    localparam logic [2:0] DEPTH_8BPP  = 3'd3;
    localparam logic [2:0] DEPTH_MODE7 = 3'd4;

    // tile lengths in bytes
    localparam logic [7:0] LEN_2BPP  = 8'd16;
    localparam logic [7:0] LEN_4BPP  = 8'd32;
    localparam logic [7:0] LEN_8BPP  = 8'd64;
    localparam logic [7:0] LEN_MODE7 = 8'd128;

    // store geometry: two banks of eight 64-bit rows, one byte lane per plane
    localparam int BANKS    = 2;
    localparam int ROWS     = 8;
    localparam int LANES    = 8;
    localparam int WORD_W   = 64;
    localparam int RAM_DEPTH = BANKS * ROWS;

    // one byte lane write into the tile store
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [2:0] row;
        logic [2:0] lane;
        logic [7:0] data;
    } wr_req_t;

    // one finished tile waiting for row output
    typedef struct packed {
        logic [2:0] depth;
        logic [7:0] offset;
        logic       h_flip;
        logic       v_flip;
    } job_t;

    // job queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
        logic wr_ptr;
        logic rd_ptr;
    } q_stat_t;

    // bytes per tile, zero when inactive
    function automatic logic [7:0] tile_len(input logic [2:0] depth);
        logic [7:0] len;
        case (depth)
            DEPTH_2BPP:  len = LEN_2BPP;
            DEPTH_4BPP:  len = LEN_4BPP;
            DEPTH_8BPP:  len = LEN_8BPP;
            DEPTH_MODE7: len = LEN_MODE7;
            default:     len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/ptrd_tile_ram.sv =====
// ----------------------------------------------------------------------------
// ptrd_tile_ram - double-banked tile store
// 16 x 64-bit rows, byte-lane write, one registered row read per cycle.
// ----------------------------------------------------------------------------
module ptrd_tile_ram (
    input  logic                         clk,
    input  ptrd_pkg::wr_req_t            wr,
    input  logic                         rd_en,
    input  logic [3:0]                   rd_addr,
    output logic [ptrd_pkg::WORD_W-1:0]  rd_data
);

    logic [ptrd_pkg::WORD_W-1:0] mem [ptrd_pkg::RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[{wr.bank, wr.row}][{wr.lane, 3'b000} +: 8] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/ptrd_front.sv =====
// ----------------------------------------------------------------------------
// ptrd_front - byte loader
// Counts tile bytes, steers each into its row and plane lane (in mode 7
// only the even bytes), posts a job on the final byte.
// ----------------------------------------------------------------------------
module ptrd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                accept,
    input  logic [7:0]          tile_byte,
    input  logic [7:0]          pal_offset,
    input  logic                h_flip,
    input  logic                v_flip,
    input  ptrd_pkg::q_stat_t   q_stat,
    output ptrd_pkg::wr_req_t   wr,
    output logic                push,
    output ptrd_pkg::job_t      push_job
);

    logic [2:0] depth_reg;
    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic [7:0] len;
    logic [6:0] cnt;
    logic       active;
    logic       last;
    logic       mode7;
    logic [5:0] m7_idx;

    always_comb
    begin
        len    = ptrd_pkg::tile_len(depth_reg);
        active = (len != 8'd0);
        mode7  = (depth_reg == ptrd_pkg::DEPTH_MODE7);
        cnt    = ({1'b0, count_reg} >= len) ? 7'd0 : count_reg;
        last   = ({1'b0, cnt} == (len - 8'd1));
        m7_idx = cnt[6:1];

        wr.bank = q_stat.wr_ptr;
        wr.data = tile_byte;
        if (mode7)
        begin
            wr.en   = accept && active && !cnt[0];
            wr.row  = m7_idx[5:3];
            wr.lane = m7_idx[2:0];
        end
        else
        begin
            wr.en   = accept && active;
            wr.row  = cnt[3:1];
            wr.lane = {cnt[5:4], cnt[0]};
        end

        push            = accept && active && last;
        push_job.depth  = depth_reg;
        push_job.offset = pal_offset;
        push_job.h_flip = h_flip;
        push_job.v_flip = v_flip;

        count_next = count_reg;
        if (accept)
        begin
            if (!active || last)
                count_next = 7'd0;
            else
                count_next = cnt + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= ptrd_pkg::DEPTH_NONE;
            count_reg <= 7'd0;
        end
        else if (cfg_wr_en)
        begin
            depth_reg <= cfg_wr_data;
            count_reg <= 7'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/ptrd_job_queue.sv =====
// ----------------------------------------------------------------------------
// ptrd_job_queue - two-entry job queue
// Slot index doubles as the tile store bank of the job.
// ----------------------------------------------------------------------------
module ptrd_job_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ptrd_pkg::job_t      push_job,
    input  logic                pop,
    output ptrd_pkg::job_t      head,
    output ptrd_pkg::q_stat_t   stat
);

    ptrd_pkg::job_t slot_reg [ptrd_pkg::BANKS];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;

        stat.full   = (count_reg == 2'd2);
        stat.empty  = (count_reg == 2'd0);
        stat.wr_ptr = wr_ptr_reg;
        stat.rd_ptr = rd_ptr_reg;
        head        = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/ptrd_back.sv =====
// ----------------------------------------------------------------------------
// ptrd_back - row sequencer
// Reads one stored row per issue, decodes eight pixels, holds the result.
// ----------------------------------------------------------------------------
module ptrd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptrd_pkg::job_t               head,
    input  ptrd_pkg::q_stat_t            q_stat,
    output logic                         pop,
    output logic                         rd_en,
    output logic [3:0]                   rd_addr,
    input  logic [ptrd_pkg::WORD_W-1:0]  rd_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   row_index,
    output logic [7:0]                   pix0,
    output logic [7:0]                   pix1,
    output logic [7:0]                   pix2,
    output logic [7:0]                   pix3,
    output logic [7:0]                   pix4,
    output logic [7:0]                   pix5,
    output logic [7:0]                   pix6,
    output logic [7:0]                   pix7,
    output logic [7:0]                   opaque_mask,
    output logic                         last_row
);

    logic [2:0] issue_row_reg;
    logic       pend_reg;
    logic [2:0] pend_row_reg;
    logic       out_valid_reg;
    logic [2:0] row_index_reg;
    logic [7:0] pix_reg [ptrd_pkg::LANES];
    logic [7:0] mask_reg;
    logic       last_reg;

    logic       mode7;
    logic [2:0] rd_row;
    logic [7:0] plane_en;
    logic [7:0] val  [ptrd_pkg::LANES];
    logic [7:0] pix  [ptrd_pkg::LANES];
    logic [7:0] mask;

    always_comb
    begin
        mode7 = (head.depth == ptrd_pkg::DEPTH_MODE7);

        // issue only when the output slot is free by the time data lands
        rd_en   = !q_stat.empty && !pend_reg && (!out_valid_reg || !out_stall);
        rd_row  = (!mode7 && head.v_flip) ? ~issue_row_reg : issue_row_reg;
        rd_addr = {q_stat.rd_ptr, rd_row};
        pop     = pend_reg && (pend_row_reg == 3'd7);

        case (head.depth)
            ptrd_pkg::DEPTH_2BPP: plane_en = 8'h03;
            ptrd_pkg::DEPTH_4BPP: plane_en = 8'h0f;
            default:              plane_en = 8'hff;
        endcase

        for (int c = 0; c < ptrd_pkg::LANES; c++)
        begin
            if (mode7)
            begin
                val[c] = rd_data[c*8 +: 8];
                pix[c] = val[c];
            end
            else
            begin
                for (int k = 0; k < ptrd_pkg::LANES; k++)
                begin
                    // column c sits at bit 7-c of each plane, mirrored by h_flip
                    val[c][k] = plane_en[k] &
                                rd_data[k*8 + (head.h_flip ? c : 7 - c)];
                end
                pix[c] = (val[c] != 8'd0) ? (head.offset + val[c]) : 8'd0;
            end
            mask[c] = (val[c] != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_row_reg <= 3'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (rd_en)
                issue_row_reg <= issue_row_reg + 3'd1;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            pend_row_reg <= issue_row_reg;
        if (pend_reg)
        begin
            row_index_reg <= pend_row_reg;
            mask_reg      <= mask;
            last_reg      <= (pend_row_reg == 3'd7);
            for (int c = 0; c < ptrd_pkg::LANES; c++)
                pix_reg[c] <= pix[c];
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_index_reg;
    assign pix0        = pix_reg[0];
    assign pix1        = pix_reg[1];
    assign pix2        = pix_reg[2];
    assign pix3        = pix_reg[3];
    assign pix4        = pix_reg[4];
    assign pix5        = pix_reg[5];
    assign pix6        = pix_reg[6];
    assign pix7        = pix_reg[7];
    assign opaque_mask = mask_reg;
    assign last_row    = last_reg;

endmodule

// ===== src/planar_tile_row_decoder_top.sv =====
// ----------------------------------------------------------------------------
// planar_tile_row_decoder_top - 8x8 tile loader and row decoder
// Loads a tile byte by byte and emits its eight decoded rows.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_stall    | tile_byte, pal_offset, h_flip, v_flip
//  out      | out_valid / out_stall  | row_index, pix0..pix7, opaque_mask,
//           |                        | last_row
//  cfg      | cfg_wr_en              | cfg_wr_data (tile_depth)
//
//  Input takes one byte per cycle unless in_stall is high; a tile is 16,
//  32, 64 or 128 transfers. Output reads each row from the tile store,
//  then decodes it into the output register before the next row is read.
//  The tile store has two banks; loading stalls only when both hold tiles
//  still waiting for output. Reset clears counters, queue and the output
//  valid; store contents are not cleared. A tile_depth write drops a
//  partly loaded tile.
//
module planar_tile_row_decoder_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  tile_byte,
    input  logic [7:0]  pal_offset,
    input  logic        h_flip,
    input  logic        v_flip,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  row_index,
    output logic [7:0]  pix0,
    output logic [7:0]  pix1,
    output logic [7:0]  pix2,
    output logic [7:0]  pix3,
    output logic [7:0]  pix4,
    output logic [7:0]  pix5,
    output logic [7:0]  pix6,
    output logic [7:0]  pix7,
    output logic [7:0]  opaque_mask,
    output logic        last_row
);

    ptrd_pkg::q_stat_t            q_stat;
    ptrd_pkg::wr_req_t            wr;
    ptrd_pkg::job_t               push_job;
    ptrd_pkg::job_t               head;
    logic                         push;
    logic                         pop;
    logic                         accept;
    logic                         rd_en;
    logic [3:0]                   rd_addr;
    logic [ptrd_pkg::WORD_W-1:0]  rd_data;

    // both banks busy: hold off the loader
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    ptrd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .tile_byte   (tile_byte),
        .pal_offset  (pal_offset),
        .h_flip      (h_flip),
        .v_flip      (v_flip),
        .q_stat      (q_stat),
        .wr          (wr),
        .push        (push),
        .push_job    (push_job)
    );

    ptrd_tile_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one job per finished tile; slot number selects the store bank
    ptrd_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    ptrd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .pix0        (pix0),
        .pix1        (pix1),
        .pix2        (pix2),
        .pix3        (pix3),
        .pix4        (pix4),
        .pix5        (pix5),
        .pix6        (pix6),
        .pix7        (pix7),
        .opaque_mask (opaque_mask),
        .last_row    (last_row)
    );

endmodule

// ===== tb/ptrd_row_check_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrd_row_check_pkg - row expectations for the planar tile row decoder bench
// Tracks tile depth, byte position and tile contents, decodes each finished
// tile into its eight rows and checks the rows that come out of the block.
// ----------------------------------------------------------------------------
package ptrd_row_check_pkg;

    import ptrd_pkg::*;

    typedef struct {
        logic [2:0] row_index;
        logic [7:0] pix [8];
        logic [7:0] opaque_mask;
        logic       last_row;
    } tile_row_t;

    class tile_row_scoreboard;
        logic [2:0] depth;
        int         byte_count;
        logic [7:0] tile_store [64];
        tile_row_t  rows_due [$];
        int         mismatches;
        int         rows_checked;
        int         tiles_decoded;

        function new();
            depth         = DEPTH_NONE;
            byte_count    = 0;
            mismatches    = 0;
            rows_checked  = 0;
            tiles_decoded = 0;
            foreach (tile_store[i])
                tile_store[i] = 8'h00;
        endfunction

        // register write also drops a partly loaded tile
        function void set_depth(logic [2:0] d);
            depth      = d;
            byte_count = 0;
        endfunction

        function int tile_bytes();
            case (depth)
                DEPTH_2BPP:  return int'(LEN_2BPP);
                DEPTH_4BPP:  return int'(LEN_4BPP);
                DEPTH_8BPP:  return int'(LEN_8BPP);
                DEPTH_MODE7: return int'(LEN_MODE7);
                default:     return 0;
            endcase
        endfunction

        function int rows_pending();
            return rows_due.size();
        endfunction

        function void note_transfer(logic [7:0] data, logic [7:0] offset,
                                    logic hf, logic vf);
            int len;
            int cnt;
            len = tile_bytes();
            cnt = byte_count;
            if (len == 0) begin
                byte_count = 0;
                return;
            end
            if (cnt >= len)
                cnt = 0;
            // mode 7 keeps only the even bytes
            if (depth == DEPTH_MODE7) begin
                if (cnt % 2 == 0)
                    tile_store[cnt / 2] = data;
            end else begin
                tile_store[cnt % 64] = data;
            end
            if (cnt + 1 < len) begin
                byte_count = cnt + 1;
            end else begin
                byte_count = 0;
                decode_tile(offset, hf, vf);
            end
        endfunction

        function void decode_tile(logic [7:0] offset, logic hf, logic vf);
            tile_row_t  exp_row;
            int         planes;
            int         r;
            int         c;
            int         k;
            int         sr;
            int         sc;
            logic [7:0] v;
            planes = (depth == DEPTH_2BPP) ? 2 : (depth == DEPTH_4BPP) ? 4 : 8;
            for (r = 0; r < 8; r++) begin
                exp_row.row_index   = 3'(r);
                exp_row.opaque_mask = 8'h00;
                exp_row.last_row    = (r == 7);
                for (c = 0; c < 8; c++) begin
                    if (depth == DEPTH_MODE7) begin
                        v = tile_store[r * 8 + c];
                        exp_row.pix[c] = v;
                    end else begin
                        sr = vf ? 7 - r : r;
                        sc = hf ? 7 - c : c;
                        v  = 8'h00;
                        for (k = 0; k < planes; k++)
                            if (tile_store[16 * (k / 2) + 2 * sr + (k % 2)][7 - sc])
                                v[k] = 1'b1;
                        exp_row.pix[c] = (v != 8'h00) ? 8'(offset + v) : 8'h00;
                    end
                    exp_row.opaque_mask[c] = (v != 8'h00);
                end
                rows_due.push_back(exp_row);
            end
            tiles_decoded++;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("  row check: %s", what);
        endtask

        task check_row(tile_row_t got);
            tile_row_t want;
            int        c;
            if (rows_due.size() == 0) begin
                report($sformatf("row %0d arrived with no tile loaded", got.row_index));
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            if (got.row_index !== want.row_index)
                report($sformatf("row_index got %0d want %0d",
                                 got.row_index, want.row_index));
            for (c = 0; c < 8; c++)
                if (got.pix[c] !== want.pix[c])
                    report($sformatf("row %0d pix%0d got %02h want %02h",
                                     want.row_index, c, got.pix[c], want.pix[c]));
            if (got.opaque_mask !== want.opaque_mask)
                report($sformatf("row %0d opaque_mask got %02h want %02h",
                                 want.row_index, got.opaque_mask, want.opaque_mask));
            if (got.last_row !== want.last_row)
                report($sformatf("row %0d last_row got %0b want %0b",
                                 want.row_index, got.last_row, want.last_row));
        endtask
    endclass

endpackage

// ===== tb/planar_tile_row_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// planar_tile_row_decoder_top_test - bench for the planar tile row decoder
// Streams 2, 4 and 8 bpp tiles into the block with random gaps and output
// stalls, three tiles back to back so both banks fill, decodes each tile on
// the side and compares all eight rows field by field. Covers depth none,
// ignored depth codes and tiles cut short by a depth write, mode 7 included.
// ----------------------------------------------------------------------------
module planar_tile_row_decoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ptrd_pkg::*;
    import ptrd_row_check_pkg::*;

    // idle margin after the last due row, sized to cover any row still in
    // flight plus the two-bank queue behind it
    localparam int SETTLE_CYCLES  = 40;
    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [2:0] cfg_wr_data = DEPTH_NONE;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] tile_byte   = 8'h00;
    logic [7:0] pal_offset  = 8'h00;
    logic       h_flip      = 1'b0;
    logic       v_flip      = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] row_index;
    logic [7:0] pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7;
    logic [7:0] opaque_mask;
    logic       last_row;

    tile_row_scoreboard sb;

    // gap and stall enables; cleared for the long run without idling
    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;

    int quiet_cycles = 0;
    int bytes_sent   = 0;

    always #10 clk = ~clk;

    planar_tile_row_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .tile_byte   (tile_byte),
        .pal_offset  (pal_offset),
        .h_flip      (h_flip),
        .v_flip      (v_flip),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .pix0        (pix0),
        .pix1        (pix1),
        .pix2        (pix2),
        .pix3        (pix3),
        .pix4        (pix4),
        .pix5        (pix5),
        .pix6        (pix6),
        .pix7        (pix7),
        .opaque_mask (opaque_mask),
        .last_row    (last_row)
    );

    // Output stall: about 6 percent of the time, one decision per edge so the
    // stall never gets two updates in one step.
    always @(posedge clk)
        out_stall <= out_idle_on && ($urandom_range(99) < 6);

    // Transfer monitor. Samples at the edge, before any of this edge's
    // updates land, so both channels see the values the block saw.
    always @(posedge clk)
    begin
        tile_row_t got;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_transfer(tile_byte, pal_offset, h_flip, v_flip);
                bytes_sent++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                got.row_index   = row_index;
                got.pix[0]      = pix0;
                got.pix[1]      = pix1;
                got.pix[2]      = pix2;
                got.pix[3]      = pix3;
                got.pix[4]      = pix4;
                got.pix[5]      = pix5;
                got.pix[6]      = pix6;
                got.pix[7]      = pix7;
                got.opaque_mask = opaque_mask;
                got.last_row    = last_row;
                sb.check_row(got);
                moved = 1'b1;
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog: a hung handshake shows up as a long run with no transfer.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles, %0d rows still due",
                 WATCHDOG_LIMIT, sb.rows_pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Byte mix with plenty of zero bytes (transparent pixels) and all-ones
    // bytes (top pixel values) next to plain random ones.
    function automatic logic [7:0] pixel_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return 8'h00;
        if (pick < 40)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // One transfer on the input channel. An optional one-cycle gap drops
    // valid first; otherwise valid stays high straight into the next byte.
    task automatic send_byte(input logic [7:0] data, input logic [7:0] offset,
                             input logic hf, input logic vf);
        if (in_idle_on && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        tile_byte  <= data;
        pal_offset <= offset;
        h_flip     <= hf;
        v_flip     <= vf;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Random bytes; offset and flips change every byte, only the last byte
    // of a tile should count.
    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_byte(pixel_byte(), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Drop valid, wait for every due row, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.rows_pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Depth register write, only with the block idle.
    task automatic write_depth(input logic [2:0] d);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_depth(d);
    endtask

    // Whole tiles back to back at one depth.
    task automatic run_tiles(input logic [2:0] d, input int tiles);
        write_depth(d);
        send_random(tiles * sb.tile_bytes());
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----

        // depth none straight after reset: bytes are taken and dropped
        send_byte(8'hFF, 8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 8'h00, 1'b0, 1'b0);

        // the unused depth codes behave like none
        write_depth(3'd5);
        send_byte(8'hA5, 8'h5A, 1'b1, 1'b0);
        write_depth(3'd6);
        send_byte(8'h5A, 8'hA5, 1'b0, 1'b1);
        write_depth(3'd7);
        send_byte(8'h81, 8'h7E, 1'b1, 1'b1);

        // 2 bpp tile with pixel values 1, 3, 2 and 0 in column pairs and a
        // different plane 0 byte per row; offset 0xff wraps value 1 to index
        // 0 while the pixel stays opaque, both flips on. Offset and flips are
        // zero until the final byte to show they are taken from it only.
        write_depth(DEPTH_2BPP);
        for (int i = 0; i < 16; i++)
            send_byte((i % 2 == 0) ? (8'hF0 ^ 8'(i / 2)) : 8'h3C,
                      (i == 15) ? 8'hFF : 8'h00, i == 15, i == 15);

        // two more 2 bpp tiles right behind it: with output stalls the
        // third tile finds both banks busy and the input stall kicks in
        send_random(32);

        // partial tile; the depth write in the next phase must drop it
        send_random(4);

        // ---- random part ----

        run_tiles(DEPTH_4BPP, 1);

        // cut a 4 bpp tile short with a switch to 8 bpp
        send_random(5);

        // long stretch with no gaps and no stalls on either side
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_tiles(DEPTH_8BPP, 1);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        // mode 7 tile cut short, then an ignored code again
        write_depth(DEPTH_MODE7);
        send_random(12);

        // finish on an unused code and on none
        write_depth(3'd6);
        send_random(3);
        write_depth(DEPTH_NONE);
        send_random(3);

        settle();

        $display("covered %0d input bytes, %0d tiles, %0d rows checked;",
                 bytes_sent, sb.tiles_decoded, sb.rows_checked);
        $display("depths none, 2/4/8 bpp, mode 7 loads, unused codes, full queue, "
                 + "dropped tiles");
        if (sb.mismatches == 0 && sb.rows_pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ptrd_pkg.sv
src/ptrd_tile_ram.sv
src/ptrd_front.sv
src/ptrd_job_queue.sv
src/ptrd_back.sv
src/planar_tile_row_decoder_top.sv
tb/ptrd_row_check_pkg.sv
tb/planar_tile_row_decoder_top_test.sv
